/* hw/rtl/tra_pkg.sv */
// ----------------------------------------------------------------------------
// tra_pkg
// Shared types and constants of the tied rank assignment block: item and
// result payloads, the run record that travels from front to back, widths.
// ----------------------------------------------------------------------------
package tra_pkg;

  localparam int KEY_W      = 32;
  localparam int POS_W      = 7;
  localparam int RANK_W     = 8;
  localparam int TIE_W      = 18;
  localparam int TIE_ACC_W  = 19;
  localparam int SQ_W       = 13;

  localparam int MAX_N      = 64;
  localparam int KEY_WIDTH  = 32;
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_x2;
    logic [TIE_W-1:0]  tie_sum;
    logic              overflow;
    logic              set_end;
  } out_t;

  // one closed run of equal keys
  typedef struct packed {
    logic [RANK_W-1:0] rank_x2;
    logic [POS_W-1:0]  len;
    logic [TIE_W-1:0]  tie_sum;
    logic              overflow;
    logic              set_end;
  } run_t;

endpackage

/* hw/rtl/tra_front.sv */
// ----------------------------------------------------------------------------
// tra_front
// Accepts sorted keys, tracks runs of equal keys and the tie correction, and
// emits one run record per closed run into the run queue.
// ----------------------------------------------------------------------------
module tra_front #(
  parameter int MaxN     = tra_pkg::MAX_N,
  parameter int KeyWidth = tra_pkg::KEY_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  tra_pkg::in_t  in_data_i,
  output logic          rec_push_o,
  output tra_pkg::run_t rec_data_o,
  input  logic          rec_full_i
);

  localparam int CmpW = (KeyWidth < tra_pkg::KEY_W) ? KeyWidth : tra_pkg::KEY_W;
  localparam logic [tra_pkg::POS_W-1:0] MaxPos = tra_pkg::POS_W'(MaxN);

  logic [CmpW-1:0]                 prev_key_q, prev_key_d;
  logic                            have_prev_q, have_prev_d;
  logic [tra_pkg::POS_W-1:0]       start_q, start_d;
  logic [tra_pkg::POS_W-1:0]       len_q, len_d;
  logic [tra_pkg::SQ_W-1:0]        sq_q, sq_d;
  logic [tra_pkg::TIE_ACC_W-1:0]   cube_q, cube_d;
  logic [tra_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [tra_pkg::TIE_ACC_W-1:0]   tie_q, tie_d;
  logic                            ovf_q, ovf_d;
  logic                            pend_valid_q, pend_valid_d;
  tra_pkg::run_t                   pend_q, pend_d;

  logic                            accept;
  logic                            in_range;
  logic                            match;
  logic                            close_prev;
  logic                            b_valid;
  logic [CmpW-1:0]                 key_c;
  logic [tra_pkg::POS_W-1:0]       start_n, len_n;
  logic [tra_pkg::SQ_W-1:0]        sq_n;
  logic [tra_pkg::TIE_ACC_W-1:0]   cube_n, tie_n, sum_sl, tie_a, tie_b;
  logic                            ovf_n;
  tra_pkg::run_t                   rec_a, rec_b;

  assign full   = pend_valid_q | rec_full_i;
  assign accept = push & ~full;
  assign key_c  = in_data_i.key[CmpW-1:0];

  always_comb begin
    in_range   = pos_q < MaxPos;
    match      = have_prev_q && (key_c == prev_key_q);
    close_prev = in_range && have_prev_q && !match;
    tie_a      = tie_q + cube_q;
    sum_sl     = tra_pkg::TIE_ACC_W'(sq_q) + tra_pkg::TIE_ACC_W'(len_q);

    start_n = start_q;
    len_n   = len_q;
    sq_n    = sq_q;
    cube_n  = cube_q;
    if (in_range) begin
      if (match) begin
        len_n  = len_q + 1'b1;
        sq_n   = sq_q + tra_pkg::SQ_W'({len_q, 1'b1});
        cube_n = cube_q + (sum_sl << 1) + sum_sl;
      end else begin
        start_n = pos_q + 1'b1;
        len_n   = tra_pkg::POS_W'(1);
        sq_n    = tra_pkg::SQ_W'(1);
        cube_n  = '0;
      end
    end
    tie_n   = close_prev ? tie_a : tie_q;
    ovf_n   = ovf_q | ~in_range;
    tie_b   = tie_n + cube_n;
    b_valid = in_data_i.last && (have_prev_q || in_range);

    rec_a.rank_x2  = {start_q, 1'b0} + tra_pkg::RANK_W'(len_q) - 1'b1;
    rec_a.len      = len_q;
    rec_a.tie_sum  = tie_a[tra_pkg::TIE_W-1:0];
    rec_a.overflow = ovf_q;
    rec_a.set_end  = 1'b0;

    rec_b.rank_x2  = {start_n, 1'b0} + tra_pkg::RANK_W'(len_n) - 1'b1;
    rec_b.len      = len_n;
    rec_b.tie_sum  = tie_b[tra_pkg::TIE_W-1:0];
    rec_b.overflow = ovf_n;
    rec_b.set_end  = 1'b1;
  end

  always_comb begin
    rec_push_o = 1'b0;
    rec_data_o = pend_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (pend_valid_q) begin
      rec_push_o = ~rec_full_i;
      if (!rec_full_i) begin
        pend_valid_d = 1'b0;
      end
    end else if (accept) begin
      rec_push_o = close_prev | b_valid;
      rec_data_o = close_prev ? rec_a : rec_b;
      if (close_prev && b_valid) begin
        pend_valid_d = 1'b1;
        pend_d       = rec_b;
      end
    end
  end

  always_comb begin
    prev_key_d  = prev_key_q;
    have_prev_d = have_prev_q;
    start_d     = start_q;
    len_d       = len_q;
    sq_d        = sq_q;
    cube_d      = cube_q;
    pos_d       = pos_q;
    tie_d       = tie_q;
    ovf_d       = ovf_q;
    if (accept) begin
      if (in_data_i.last) begin
        prev_key_d  = '0;
        have_prev_d = 1'b0;
        start_d     = tra_pkg::POS_W'(1);
        len_d       = '0;
        sq_d        = '0;
        cube_d      = '0;
        pos_d       = '0;
        tie_d       = '0;
        ovf_d       = 1'b0;
      end else begin
        if (in_range && !match) begin
          prev_key_d = key_c;
        end
        have_prev_d = have_prev_q | in_range;
        start_d     = start_n;
        len_d       = len_n;
        sq_d        = sq_n;
        cube_d      = cube_n;
        pos_d       = in_range ? pos_q + 1'b1 : pos_q;
        tie_d       = tie_n;
        ovf_d       = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_key_q   <= '0;
      have_prev_q  <= 1'b0;
      start_q      <= tra_pkg::POS_W'(1);
      len_q        <= '0;
      sq_q         <= '0;
      cube_q       <= '0;
      pos_q        <= '0;
      tie_q        <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      prev_key_q   <= prev_key_d;
      have_prev_q  <= have_prev_d;
      start_q      <= start_d;
      len_q        <= len_d;
      sq_q         <= sq_d;
      cube_q       <= cube_d;
      pos_q        <= pos_d;
      tie_q        <= tie_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  a_pend_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> full)
    else $error("input taken while a run record is pending");

  a_set_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.last) |=> (pos_q == '0 && !have_prev_q && tie_q == '0))
    else $error("set state not cleared after the last key");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("position beyond the set limit");

endmodule

/* hw/rtl/tra_fifo.sv */
// ----------------------------------------------------------------------------
// tra_fifo
// Short register queue of run records between the front and the back.
// ----------------------------------------------------------------------------
module tra_fifo #(
  parameter int Depth = tra_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tra_pkg::run_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tra_pkg::run_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  tra_pkg::run_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == DepthCnt;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("run queue count out of range");

endmodule

/* hw/rtl/tra_back.sv */
// ----------------------------------------------------------------------------
// tra_back
// Expands each run record into one result per element of the run and holds
// the oldest result in an output register.
// ----------------------------------------------------------------------------
module tra_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rec_valid_i,
  input  tra_pkg::run_t rec_data_i,
  output logic          rec_pop_o,
  output logic          empty,
  input  logic          pop,
  output tra_pkg::out_t out_data_o
);

  logic [tra_pkg::POS_W-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  tra_pkg::out_t             out_q, out_d;
  logic                      load;
  logic                      last_elem;

  assign empty      = ~out_valid_q;
  assign out_data_o = out_q;
  assign load       = rec_valid_i & (~out_valid_q | pop);
  assign last_elem  = (idx_q + 1'b1) == rec_data_i.len;
  assign rec_pop_o  = load & last_elem;

  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_d.rank_x2  = rec_data_i.rank_x2;
      out_d.tie_sum  = rec_data_i.tie_sum;
      out_d.overflow = rec_data_i.overflow;
      out_d.set_end  = rec_data_i.set_end & last_elem;
      out_valid_d    = 1'b1;
      idx_d          = last_elem ? '0 : idx_q + 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i |-> (idx_q < rec_data_i.len))
    else $error("element index beyond run length");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rec_valid_i |-> (idx_q == '0))
    else $error("element index left over with no run queued");

endmodule

/* hw/rtl/tied_rank_assignment_top.sv */
// ----------------------------------------------------------------------------
// tied_rank_assignment_top
// Fractional midranks with tie correction over an ascending-sorted key set.
// ----------------------------------------------------------------------------
// Keys of one sorted set enter one per cycle, the final key marked by last;
// each of the first MaxN keys of a set gives exactly one result, emitted
// when its run of equal keys closes. The front takes a key every cycle while
// its run queue has room, except that a key which both closes a run and ends
// the set produces two run records and holds the input while the second waits.
// The back drains one result per cycle from its output register while results
// are popped, so the sustained rate is one key per cycle; a result passes
// through the run queue and the output register after the key closing its run.
module tied_rank_assignment_top #(
  parameter int MaxN      = tra_pkg::MAX_N,
  parameter int KeyWidth  = tra_pkg::KEY_WIDTH,
  parameter int FifoDepth = tra_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  tra_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output tra_pkg::out_t out_data_o
);

  logic          rec_push;
  logic          rec_full;
  logic          rec_valid;
  logic          rec_pop;
  tra_pkg::run_t rec_wdata;
  tra_pkg::run_t rec_rdata;

  tra_front #(
    .MaxN     (MaxN),
    .KeyWidth (KeyWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .rec_push_o (rec_push),
    .rec_data_o (rec_wdata),
    .rec_full_i (rec_full)
  );

  tra_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_wdata),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .valid_o (rec_valid),
    .data_o  (rec_rdata)
  );

  tra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_data_i  (rec_rdata),
    .rec_pop_o   (rec_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

/* test/tied_rank_assignment_top_tb.sv */
// ----------------------------------------------------------------------------
// tied_rank_assignment_top_tb
// Self-checking testbench for the tied rank assignment block. Sorted key sets
// go in through the push side. A midrank predictor tracks runs of equal keys,
// the running tie correction and the overflow flag, and queues one expected
// result per in-range key. Every popped result is compared field by field
// with the oldest expected one. Test phases cover directed corner sets, random
// sorted sets under several idle patterns, over-length sets and unsorted noise.
// ----------------------------------------------------------------------------
module tied_rank_assignment_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 20;
  localparam int MaxPrinted = 30;

  logic          clk_i;
  logic          rst_ni;
  logic          push;
  logic          full;
  tra_pkg::in_t  in_data_i;
  logic          empty;
  logic          pop;
  tra_pkg::out_t out_data_o;

  tied_rank_assignment_top i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  logic [tra_pkg::KEY_W-1:0]     prev_key;
  bit                            have_prev;
  logic [tra_pkg::POS_W-1:0]     run_start;
  logic [tra_pkg::POS_W-1:0]     run_len;
  logic [tra_pkg::POS_W-1:0]     set_pos;
  logic [tra_pkg::TIE_ACC_W-1:0] tie_acc;
  bit                            set_overflow;

  tra_pkg::out_t expected_ranks[$];

  int error_count;
  int keys_sent;
  int sets_sent;
  int overflow_sets;
  int results_checked;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  task automatic report_error(input string msg);
    if (error_count < MaxPrinted) $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic void clear_set_state();
    prev_key     = '0;
    have_prev    = 1'b0;
    run_start    = 7'd1;
    run_len      = '0;
    set_pos      = '0;
    tie_acc      = '0;
    set_overflow = 1'b0;
  endfunction

  function automatic void close_tie_run(input bit ends_set, inout int emitted);
    int            t;
    tra_pkg::out_t res;
    t       = int'(run_len);
    tie_acc = tra_pkg::TIE_ACC_W'(int'(tie_acc) + t * t * t - t);
    for (int i = 0; i < t; i++) begin
      if (emitted >= tra_pkg::MAX_N) break;
      res.rank_x2  = tra_pkg::RANK_W'(2 * int'(run_start) + t - 1);
      res.tie_sum  = tie_acc[tra_pkg::TIE_W-1:0];
      res.overflow = set_overflow;
      res.set_end  = ends_set && (i == t - 1);
      expected_ranks.push_back(res);
      emitted++;
    end
    run_len = '0;
  endfunction

  function automatic void predict_midranks(input logic [tra_pkg::KEY_W-1:0] k,
                                           input logic l);
    int emitted;
    emitted = 0;
    if (set_pos < tra_pkg::MAX_N) begin
      if (have_prev && k == prev_key) begin
        run_len = run_len + 7'd1;
      end else begin
        if (have_prev) close_tie_run(1'b0, emitted);
        run_start = set_pos + 7'd1;
        run_len   = 7'd1;
        prev_key  = k;
        have_prev = 1'b1;
      end
      set_pos = set_pos + 7'd1;
    end else begin
      set_overflow = 1'b1;
    end
    if (l) begin
      if (have_prev && run_len > 0) close_tie_run(1'b1, emitted);
      clear_set_state();
    end
  endfunction

  task automatic send_key(input logic [tra_pkg::KEY_W-1:0] k, input logic l);
    tra_pkg::in_t item;
    item.key  = k;
    item.last = l;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (full !== 1'b0);
    predict_midranks(k, l);
    keys_sent++;
  endtask

  task automatic send_set(input int n, input int tie_pct, input bit sorted);
    logic [tra_pkg::KEY_W-1:0] k;
    logic [tra_pkg::KEY_W-1:0] step;
    case ($urandom_range(3))
      0: k = '0;
      1: k = 32'hFFFF_FFFF - $urandom_range(200);
      default: k = $urandom;
    endcase
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(99) >= tie_pct) begin
        if (!sorted) begin
          k = $urandom;
        end else begin
          step = $urandom_range(1) ? $urandom_range(16, 1) : $urandom_range(32'h00FF_FFFF, 1);
          k    = (k > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : k + step;
        end
      end
      send_key(k, i == n - 1);
    end
    sets_sent++;
    if (n > tra_pkg::MAX_N) overflow_sets++;
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_key(32'h0000_0000, 1'b1);
    send_key(32'hFFFF_FFFF, 1'b1);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'hFFFF_FFFF, 1'b0);
    send_key(32'hFFFF_FFFF, 1'b1);
    send_key(32'd1, 1'b0);
    send_key(32'd2, 1'b0);
    send_key(32'd3, 1'b1);
    // new key together with last closes two runs
    send_key(32'd5, 1'b0);
    send_key(32'd5, 1'b0);
    send_key(32'd7, 1'b1);
    send_key(32'd7, 1'b0);
    send_key(32'd7, 1'b0);
    send_key(32'd7, 1'b1);
    // same key again starts a fresh set
    send_key(32'd7, 1'b1);
    sets_sent += 7;
  endtask

  task automatic test_sorted_sets(input int send_pct, input int recv_pct, input int n_keys);
    int start;
    int n;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start          = keys_sent;
    while (keys_sent - start < n_keys) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: n = $urandom_range(8, 1);
        6, 7, 8:          n = $urandom_range(24, 9);
        default:          n = $urandom_range(tra_pkg::MAX_N, 25);
      endcase
      send_set(n, $urandom_range(4) * 25, 1'b1);
    end
  endtask

  task automatic test_overflow();
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    send_set(tra_pkg::MAX_N + $urandom_range(4, 1), 100, 1'b1);
    send_set(tra_pkg::MAX_N, 50, 1'b1);
    send_set(tra_pkg::MAX_N + $urandom_range(6, 1), 30, 1'b1);
  endtask

  task automatic test_unsorted_noise();
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    for (int i = 0; i < 8; i++) send_set($urandom_range(8, 1), 40, 1'b0);
  endtask

  always @(posedge clk_i) begin
    tra_pkg::out_t exp_res;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_ranks.size() == 0) begin
          report_error($sformatf("unexpected result rank_x2=%0d", out_data_o.rank_x2));
        end else begin
          exp_res = expected_ranks.pop_front();
          if (out_data_o.rank_x2 !== exp_res.rank_x2)
            report_error($sformatf("rank_x2 got %0d exp %0d",
                                   out_data_o.rank_x2, exp_res.rank_x2));
          if (out_data_o.tie_sum !== exp_res.tie_sum)
            report_error($sformatf("tie_sum got %0d exp %0d",
                                   out_data_o.tie_sum, exp_res.tie_sum));
          if (out_data_o.overflow !== exp_res.overflow)
            report_error($sformatf("overflow got %0b exp %0b",
                                   out_data_o.overflow, exp_res.overflow));
          if (out_data_o.set_end !== exp_res.set_end)
            report_error($sformatf("set_end got %0b exp %0b",
                                   out_data_o.set_end, exp_res.set_end));
          results_checked++;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cycle_count     = 0;
    error_count     = 0;
    keys_sent       = 0;
    sets_sent       = 0;
    overflow_sets   = 0;
    results_checked = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    clear_set_state();
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    pop       <= 1'b0;
    in_data_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_sorted_sets(0, 0, 80);
    test_sorted_sets(80, 0, 80);
    test_sorted_sets(0, 80, 80);
    test_sorted_sets(38, 38, 80);
    test_overflow();
    test_unsorted_noise();
    push <= 1'b0;

    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d keys in %0d sets (%0d over-length), checked %0d results",
             keys_sent, sets_sent, overflow_sets, results_checked);
    $display("idle patterns: none, sender, receiver, both; %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
